// File: sv/dsil_pkg.sv
// ----------------------------------------------------------------------------
// Dedup set package
// Shared constants, action codes and the cell control struct for the
// insertion-ordered unique-value set.
// ----------------------------------------------------------------------------
`default_nettype none

package dsil_pkg;

   // Fixed widths of the request and response fields.
   localparam int ACTION_W    = 2;
   localparam int REQ_ELEM_W  = 32;
   localparam int RSP_COUNT_W = 5;

   // Defaults for the top-level parameters.
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_ELEM_WIDTH = 32;

   typedef logic [ACTION_W-1:0] action_type;

   // Action codes. Any other code behaves as a query.
   localparam action_type ACT_ADD    = 2'd0;
   localparam action_type ACT_REMOVE = 2'd1;
   localparam action_type ACT_QUERY  = 2'd2;

   // Per-cell update controls broadcast from the top level.
   typedef struct packed {
      logic load_new;   // this cell takes the key as a new entry
      logic remove_go;  // a remove is committing this cycle
   } cell_ctl_type;

endpackage : dsil_pkg

`default_nettype wire

// File: sv/dsil_cell.sv
// ----------------------------------------------------------------------------
// Dedup set cell
// One storage slot of the set: holds an entry, compares it with the key,
// and on a remove takes the entry of its upper neighbor once the matching
// slot lies at or below it.
// ----------------------------------------------------------------------------
`default_nettype none

module dsil_cell #(
   parameter int ELEM_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dsil_pkg::cell_ctl_type ctl,
   input  wire logic                  occupied,
   input  wire logic [ELEM_WIDTH-1:0] key,
   input  wire logic [ELEM_WIDTH-1:0] next_elem,
   input  wire logic                  pass_in,
   output logic                       pass_out,
   output logic [ELEM_WIDTH-1:0]      data_out,
   output logic                       hit
);
   import dsil_pkg::*;

   logic [ELEM_WIDTH-1:0] data_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic                  shift_up;

   // A slot matches only while it holds a live entry.
   assign hit_in = occupied && (data_ff == key);

   // The gap-closing run starts at the matching slot and carries upward.
   assign pass_out = pass_in | hit_ff;
   assign shift_up = ctl.remove_go & pass_out;

   // Compare result is registered ahead of the update cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   // Entry storage: load a new element or move the neighbor's entry down.
   always_ff @(posedge clock) begin
      if (ctl.load_new) begin
         data_ff <= key;
      end else if (shift_up) begin
         data_ff <= next_elem;
      end
   end

   assign data_out = data_ff;
   assign hit      = hit_ff;

endmodule : dsil_cell

`default_nettype wire

// File: sv/dedup_set_insert_remove_lookup.sv
// The response strobe rsp_valid follows the accepting edge through the compare
// in all cells, the update and the registered response.
// A new item is taken only once the registered compare stage is free; that stage
// must see the cells as left by the previous item's update.
// Reset: the held count and the pipeline flags clear; entries are not cleared.
// The response cannot be stalled; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// Dedup set top level
// Fixed-capacity, insertion-ordered set of unique values built as a row of
// compare-and-shift cells, with add, remove and membership query.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_set_insert_remove_lookup #(
   parameter int CAPACITY   = dsil_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = dsil_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire dsil_pkg::action_type             req_action,
   input  wire logic [dsil_pkg::REQ_ELEM_W-1:0]  req_element,
   output logic                                  rsp_valid,
   output logic                                  rsp_was_present,
   output logic [dsil_pkg::RSP_COUNT_W-1:0]      rsp_count,
   output logic                                  rsp_overflow
);
   import dsil_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic                  accept;
   logic                  s1_valid_ff;
   logic                  s2_valid_ff;
   action_type            action_ff;
   logic [ELEM_WIDTH-1:0] key_ff;
   logic [ELEM_WIDTH+REQ_ELEM_W-1:0] elem_wide;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [CW+RSP_COUNT_W-1:0] count_wide;

   logic                  present;
   logic                  is_add;
   logic                  is_remove;
   logic                  is_full;
   logic                  add_do;
   logic                  remove_do;
   logic                  ovf;

   logic                  rsp_valid_ff;
   logic                  rsp_was_present_ff;
   logic [RSP_COUNT_W-1:0] rsp_count_ff;
   logic                  rsp_overflow_ff;

   logic [CAPACITY-1:0]   hit_vec;
   logic [CAPACITY:0]     pass_vec;
   logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];

   // Item handshake; the compare stage must be free.
   assign accept = start && !busy;
   assign busy   = s1_valid_ff;

   // Key is compared in its low ELEM_WIDTH bits, zero-extended if wider.
   assign elem_wide = {{ELEM_WIDTH{1'b0}}, req_element};

   // Pipeline flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Request capture; held until the next accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= elem_wide[ELEM_WIDTH-1:0];
      end
   end

   // Decision logic in the update cycle.
   always_comb begin
      present   = |hit_vec;
      is_add    = (action_ff == ACT_ADD);
      is_remove = (action_ff == ACT_REMOVE);
      is_full   = (count_ff == CW'(CAPACITY));
      add_do    = s2_valid_ff && is_add && !present && !is_full;
      remove_do = s2_valid_ff && is_remove && present;
      ovf       = is_add && !present && is_full;
      count_in  = count_ff;
      if (add_do) begin
         count_in = count_ff + CW'(1);
      end else if (remove_do) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_wide = {{RSP_COUNT_W{1'b0}}, count_in};

   // Row of cells; the remove run starts at the matching slot, the chain's bottom input is tied low.
   assign pass_vec[0] = 1'b0;

   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_ctl_type          ctl;
      logic [ELEM_WIDTH-1:0] next_elem;

      assign ctl.load_new  = add_do && (count_ff == CW'(gi));
      assign ctl.remove_go = remove_do;

      if (gi == CAPACITY - 1) begin : g_top
         assign next_elem = cell_data[gi];
      end else begin : g_mid
         assign next_elem = cell_data[gi + 1];
      end

      dsil_cell #(
         .ELEM_WIDTH(ELEM_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .occupied (CW'(gi) < count_ff),
         .key      (key_ff),
         .next_elem(next_elem),
         .pass_in  (pass_vec[gi]),
         .pass_out (pass_vec[gi + 1]),
         .data_out (cell_data[gi]),
         .hit      (hit_vec[gi])
      );
   end

   // Held count and the registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         rsp_was_present_ff <= present;
         rsp_count_ff       <= count_wide[RSP_COUNT_W-1:0];
         rsp_overflow_ff    <= ovf;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_present = rsp_was_present_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_overflow    = rsp_overflow_ff;

endmodule : dedup_set_insert_remove_lookup

`default_nettype wire

// File: sv/dsil_checker.sv
// ----------------------------------------------------------------------------
// Dedup set port checker
// Watches the top-level ports for handshake timing and response consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dsil_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_was_present,
   input wire logic rsp_overflow
);

   // Every accepted item yields its response.
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing after accepted item");

   // No response appears without an item accepted before it.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("response without accepted item");

   // The block is busy in the cycle after it accepts an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accepting an item");

   // A dropped add can only concern an absent element.
   a_ovf_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> !rsp_was_present)
      else $error("overflow reported for a present element");

endmodule : dsil_checker

bind dedup_set_insert_remove_lookup dsil_checker u_dsil_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_was_present(rsp_was_present),
   .rsp_overflow   (rsp_overflow)
);

`default_nettype wire
